// File: rtl/abe_pkg.sv
package abe_pkg;

    // Array geometry
    localparam int Depth    = 64;
    localparam int WordBits = 16;
    localparam int AddrBits = $clog2(Depth);
    localparam int LenBits  = $clog2(Depth + 1);

    // Port field widths
    localparam int CfgBits  = 7;
    localparam int CmdBits  = 3;
    localparam int PosBits  = 6;
    localparam int ValBits  = 16;
    localparam int IdxBits  = 6;
    localparam int RdBits   = 16;

    localparam logic [CfgBits-1:0] LengthReset = 7'd64;

    // Microprogram step counter
    localparam int StepBits  = 5;
    localparam int StepCount = 20;

    typedef logic [AddrBits-1:0] t_addr;
    typedef logic [WordBits-1:0] t_word;
    typedef logic [LenBits-1:0]  t_len;
    typedef logic [StepBits-1:0] t_step;

    typedef enum logic [CmdBits-1:0] {
        CmdWrite  = 3'd0,
        CmdRead   = 3'd1,
        CmdSwap   = 3'd2,
        CmdRotR   = 3'd3,
        CmdRotL   = 3'd4,
        CmdSearch = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ASelPtr,
        ASelStep,
        ASelBase,
        ASelPos
    } t_asel;

    typedef enum logic [1:0] {
        WSelKey,
        WSelRdata,
        WSelTmp
    } t_wsel;

    typedef enum logic [2:0] {
        PtrHold,
        PtrStep,
        PtrRot,
        PtrSwap,
        PtrSearch
    } t_ptr_op;

    typedef enum logic [2:0] {
        EmitNone,
        EmitAck,
        EmitRead,
        EmitMatch,
        EmitFinal
    } t_emit;

    typedef enum logic [2:0] {
        CondNext,
        CondAlways,
        CondDispatch,
        CondShort,
        CondEmpty,
        CondNotEnd,
        CondStepEnd
    } t_cond;

    // One control word of the microprogram
    typedef struct packed {
        logic    in_rdy;
        t_asel   addr_sel;
        logic    ram_we;
        logic    ram_re;
        t_wsel   wd_sel;
        logic    tmp_ld;
        t_ptr_op ptr_op;
        t_emit   emit;
        t_cond   cond;
        t_step   target;
    } t_ctrl;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic               accept;
        logic [CmdBits-1:0] cmd;
        logic               short_len;
        logic               empty;
        logic               at_end;
        logic               step_end;
        logic               stall;
    } t_stat;

    // Program entry points and steps
    localparam t_step StepIdle = 5'd0;
    localparam t_step StepWr   = 5'd1;
    localparam t_step StepRd0  = 5'd2;
    localparam t_step StepRd1  = 5'd3;
    localparam t_step StepRot0 = 5'd4;
    localparam t_step StepRot1 = 5'd5;
    localparam t_step StepRot2 = 5'd6;
    localparam t_step StepRot3 = 5'd7;
    localparam t_step StepRot4 = 5'd8;
    localparam t_step StepRot5 = 5'd9;
    localparam t_step StepSw0  = 5'd10;
    localparam t_step StepSw1  = 5'd11;
    localparam t_step StepSw2  = 5'd12;
    localparam t_step StepSw3  = 5'd13;
    localparam t_step StepSw4  = 5'd14;
    localparam t_step StepAck  = 5'd15;
    localparam t_step StepSr0  = 5'd16;
    localparam t_step StepSr1  = 5'd17;
    localparam t_step StepSr2  = 5'd18;
    localparam t_step StepSr3  = 5'd19;

    function automatic t_step dispatch(logic [CmdBits-1:0] cmd);
        t_step s;
        unique case (cmd)
            CmdWrite:  s = StepWr;
            CmdRead:   s = StepRd0;
            CmdSwap:   s = StepSw0;
            CmdRotR:   s = StepRot0;
            CmdRotL:   s = StepRot0;
            CmdSearch: s = StepSr0;
            default:   s = StepAck;
        endcase
        return s;
    endfunction

    // Microprogram ROM
    function automatic t_ctrl ucode(t_step s);
        t_ctrl c;
        c.in_rdy   = 1'b0;
        c.addr_sel = ASelPtr;
        c.ram_we   = 1'b0;
        c.ram_re   = 1'b0;
        c.wd_sel   = WSelRdata;
        c.tmp_ld   = 1'b0;
        c.ptr_op   = PtrHold;
        c.emit     = EmitNone;
        c.cond     = CondNext;
        c.target   = StepIdle;
        unique case (s)
            StepIdle: begin
                c.in_rdy = 1'b1;
                c.cond   = CondDispatch;
            end
            StepWr: begin
                c.addr_sel = ASelPos;
                c.ram_we   = 1'b1;
                c.wd_sel   = WSelKey;
                c.emit     = EmitAck;
                c.cond     = CondAlways;
            end
            StepRd0: begin
                c.addr_sel = ASelPos;
                c.ram_re   = 1'b1;
            end
            StepRd1: begin
                c.emit = EmitRead;
                c.cond = CondAlways;
            end
            StepRot0: begin
                c.ptr_op = PtrRot;
                c.cond   = CondShort;
                c.target = StepAck;
            end
            StepRot1: begin
                c.ram_re = 1'b1;
            end
            StepRot2: begin
                c.tmp_ld   = 1'b1;
                c.addr_sel = ASelStep;
                c.ram_re   = 1'b1;
            end
            StepRot3: begin
                c.ram_we = 1'b1;
                c.ptr_op = PtrStep;
                c.cond   = CondStepEnd;
                c.target = StepRot5;
            end
            StepRot4: begin
                c.addr_sel = ASelStep;
                c.ram_re   = 1'b1;
                c.cond     = CondAlways;
                c.target   = StepRot3;
            end
            StepRot5: begin
                c.ram_we = 1'b1;
                c.wd_sel = WSelTmp;
                c.cond   = CondAlways;
                c.target = StepAck;
            end
            StepSw0: begin
                c.ptr_op = PtrSwap;
                c.cond   = CondShort;
                c.target = StepAck;
            end
            StepSw1: begin
                c.ram_re = 1'b1;
            end
            StepSw2: begin
                c.tmp_ld   = 1'b1;
                c.addr_sel = ASelBase;
                c.ram_re   = 1'b1;
            end
            StepSw3: begin
                c.ram_we = 1'b1;
            end
            StepSw4: begin
                c.addr_sel = ASelBase;
                c.ram_we   = 1'b1;
                c.wd_sel   = WSelTmp;
                c.ptr_op   = PtrStep;
                c.cond     = CondNotEnd;
                c.target   = StepSw1;
            end
            StepAck: begin
                c.emit = EmitAck;
                c.cond = CondAlways;
            end
            StepSr0: begin
                c.ptr_op = PtrSearch;
                c.cond   = CondEmpty;
                c.target = StepSr3;
            end
            StepSr1: begin
                c.ram_re = 1'b1;
            end
            StepSr2: begin
                c.emit   = EmitMatch;
                c.ptr_op = PtrStep;
                c.cond   = CondNotEnd;
                c.target = StepSr1;
            end
            StepSr3: begin
                c.emit = EmitFinal;
                c.cond = CondAlways;
            end
            default: begin
                c.cond = CondAlways;
            end
        endcase
        return c;
    endfunction

    // Field resizing helpers
    function automatic t_word word_of_val(logic [ValBits-1:0] v);
        logic [ValBits+WordBits-1:0] w;
        w = {{WordBits{1'b0}}, v};
        return w[WordBits-1:0];
    endfunction

    function automatic logic [RdBits-1:0] rd_of_word(t_word d);
        logic [RdBits+WordBits-1:0] w;
        w = {{RdBits{1'b0}}, d};
        return w[RdBits-1:0];
    endfunction

    function automatic logic [IdxBits-1:0] idx_of_addr(t_addr a);
        logic [IdxBits+AddrBits-1:0] w;
        w = {{IdxBits{1'b0}}, a};
        return w[IdxBits-1:0];
    endfunction

    function automatic t_addr addr_of_pos(logic [PosBits-1:0] p);
        logic [PosBits+AddrBits-1:0] w;
        w = {{AddrBits{1'b0}}, p};
        return w[AddrBits-1:0];
    endfunction

    function automatic logic pos_in_range(logic [PosBits-1:0] p);
        return 32'(p) < Depth;
    endfunction

    // Clamp the configured length to the array depth
    function automatic t_len used_len(logic [CfgBits-1:0] len);
        logic [CfgBits+LenBits-1:0] w;
        w = {{LenBits{1'b0}}, len};
        if (32'(len) > Depth) begin
            return LenBits'(Depth);
        end
        return w[LenBits-1:0];
    endfunction

endpackage

// File: rtl/abe_in_if.sv
interface abe_in_if;
    logic                          valid;
    logic                          ready;
    logic [abe_pkg::CmdBits-1:0]   command;
    logic [abe_pkg::PosBits-1:0]   position;
    logic [abe_pkg::ValBits-1:0]   value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

// File: rtl/abe_out_if.sv
interface abe_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [abe_pkg::IdxBits-1:0]   match_index;
    logic [abe_pkg::RdBits-1:0]    read_value;
    logic                          last;

    modport source (output valid, output found, output match_index,
                    output read_value, output last, input ready);
    modport sink   (input valid, input found, input match_index,
                    input read_value, input last, output ready);
endinterface

// File: rtl/array_buffer_engine_core.sv
// Array buffer engine: holds up to 64 words in a single-port RAM, of which the
// first "length" (configuration, reset 64, values above 64 act as 64) are in use.
// Commands are write, read, swap halves, rotate right, rotate left and search;
// each gives one result beat, except search, which gives one beat per matching
// index in ascending order with last on the final one, or a single beat with
// found low when nothing matches. A microprogram steps a plain datapath, one
// item at a time, with every element access going through the one RAM port; a
// result beat waits while the output register holds a beat not yet taken. A
// result waiting in the output register does not block the next item; only a
// further result beat waits for it.
module array_buffer_engine_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [abe_pkg::CfgBits-1:0]   i_cfg_wr_data,
    abe_in_if.sink                        i_item,
    abe_out_if.source                     o_res
);

    abe_pkg::t_ctrl ctrl;
    abe_pkg::t_stat stat;

    logic [abe_pkg::CfgBits-1:0] r_length;
    logic [abe_pkg::CmdBits-1:0] r_cmd;
    logic [abe_pkg::PosBits-1:0] r_pos;
    abe_pkg::t_word              r_key;
    abe_pkg::t_addr              r_ptr;
    abe_pkg::t_addr              r_end;
    abe_pkg::t_addr              r_base;
    logic                        r_dir;
    abe_pkg::t_word              r_tmp;
    logic                        r_pend_valid;
    abe_pkg::t_addr              r_pend_idx;

    logic                        r_out_valid;
    logic                        r_out_found;
    logic [abe_pkg::IdxBits-1:0] r_out_idx;
    logic [abe_pkg::RdBits-1:0]  r_out_data;
    logic                        r_out_last;

    logic                        accept;
    abe_pkg::t_len               n_len;
    abe_pkg::t_len               half;
    abe_pkg::t_len               base_len;
    abe_pkg::t_addr              last_idx;
    abe_pkg::t_addr              step_ptr;
    logic                        pos_ok;
    logic                        match;
    logic                        emit_now;
    logic                        e_found;
    logic [abe_pkg::IdxBits-1:0] e_idx;
    logic [abe_pkg::RdBits-1:0]  e_data;
    logic                        e_last;
    logic                        stall;
    logic                        go;

    logic                        ram_we;
    logic                        ram_re;
    abe_pkg::t_addr              ram_addr;
    abe_pkg::t_word              ram_wdata;
    abe_pkg::t_word              ram_rdata;

    abe_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    abe_ram #(
        .WIDTH (abe_pkg::WordBits),
        .DEPTH (abe_pkg::Depth)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Input handshake
    assign i_item.ready = ctrl.in_rdy;
    assign accept       = i_item.valid && ctrl.in_rdy;

    // Length-derived values
    assign n_len    = abe_pkg::used_len(r_length);
    assign half     = n_len >> 1;
    assign base_len = half + abe_pkg::t_len'(n_len[0]);
    assign last_idx = abe_pkg::t_addr'(n_len - abe_pkg::t_len'(1));
    assign step_ptr = r_dir ? (r_ptr - abe_pkg::t_addr'(1)) : (r_ptr + abe_pkg::t_addr'(1));
    assign pos_ok   = abe_pkg::pos_in_range(r_pos);
    assign match    = (ram_rdata == r_key);

    // Build the result beat for this step
    always_comb begin
        emit_now = 1'b0;
        e_found  = 1'b1;
        e_idx    = '0;
        e_data   = '0;
        e_last   = 1'b1;
        unique case (ctrl.emit)
            abe_pkg::EmitNone: begin
                emit_now = 1'b0;
            end
            abe_pkg::EmitAck: begin
                emit_now = 1'b1;
            end
            abe_pkg::EmitRead: begin
                emit_now = 1'b1;
                e_data   = pos_ok ? abe_pkg::rd_of_word(ram_rdata) : '0;
            end
            abe_pkg::EmitMatch: begin
                emit_now = match && r_pend_valid;
                e_idx    = abe_pkg::idx_of_addr(r_pend_idx);
                e_last   = 1'b0;
            end
            abe_pkg::EmitFinal: begin
                emit_now = 1'b1;
                e_found  = r_pend_valid;
                e_idx    = r_pend_valid ? abe_pkg::idx_of_addr(r_pend_idx) : '0;
            end
            default: begin
                emit_now = 1'b0;
            end
        endcase
    end

    // Hold the step while a beat must wait for the output register
    assign stall = emit_now && r_out_valid && !o_res.ready;
    assign go    = !stall;

    // Status for the sequencer
    assign stat.accept    = accept;
    assign stat.cmd       = i_item.command;
    assign stat.short_len = (n_len < abe_pkg::t_len'(2));
    assign stat.empty     = (n_len == '0);
    assign stat.at_end    = (r_ptr == r_end);
    assign stat.step_end  = (step_ptr == r_end);
    assign stat.stall     = stall;

    // RAM port
    assign ram_we = ctrl.ram_we && go && ((ctrl.addr_sel != abe_pkg::ASelPos) || pos_ok);
    assign ram_re = ctrl.ram_re && go;

    always_comb begin
        unique case (ctrl.addr_sel)
            abe_pkg::ASelPtr:  ram_addr = r_ptr;
            abe_pkg::ASelStep: ram_addr = step_ptr;
            abe_pkg::ASelBase: ram_addr = r_ptr + r_base;
            abe_pkg::ASelPos:  ram_addr = abe_pkg::addr_of_pos(r_pos);
            default:           ram_addr = r_ptr;
        endcase
    end

    always_comb begin
        unique case (ctrl.wd_sel)
            abe_pkg::WSelKey:   ram_wdata = r_key;
            abe_pkg::WSelRdata: ram_wdata = ram_rdata;
            abe_pkg::WSelTmp:   ram_wdata = r_tmp;
            default:            ram_wdata = ram_rdata;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length     <= abe_pkg::LengthReset;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_length <= i_cfg_wr_data;
            end
            if (ctrl.ptr_op == abe_pkg::PtrSearch) begin
                r_pend_valid <= 1'b0;
            end else if (ctrl.emit == abe_pkg::EmitMatch && go && match) begin
                r_pend_valid <= 1'b1;
            end
            if (go && emit_now) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Latch the command beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_item.command;
            r_pos <= i_item.position;
            r_key <= abe_pkg::word_of_val(i_item.value);
        end
    end

    // Walk pointer, loop bounds and carried element
    always_ff @(posedge i_clk) begin
        if (go) begin
            if (ctrl.tmp_ld) begin
                r_tmp <= ram_rdata;
            end
            if (ctrl.emit == abe_pkg::EmitMatch && match) begin
                r_pend_idx <= r_ptr;
            end
            unique case (ctrl.ptr_op)
                abe_pkg::PtrHold: begin
                    r_ptr <= r_ptr;
                end
                abe_pkg::PtrStep: begin
                    r_ptr <= step_ptr;
                end
                abe_pkg::PtrRot: begin
                    if (r_cmd == abe_pkg::CmdRotR) begin
                        r_ptr <= last_idx;
                        r_end <= '0;
                        r_dir <= 1'b1;
                    end else begin
                        r_ptr <= '0;
                        r_end <= last_idx;
                        r_dir <= 1'b0;
                    end
                end
                abe_pkg::PtrSwap: begin
                    r_ptr  <= '0;
                    r_end  <= abe_pkg::t_addr'(half - abe_pkg::t_len'(1));
                    r_base <= abe_pkg::t_addr'(base_len);
                    r_dir  <= 1'b0;
                end
                abe_pkg::PtrSearch: begin
                    r_ptr <= '0;
                    r_end <= last_idx;
                    r_dir <= 1'b0;
                end
                default: begin
                    r_ptr <= r_ptr;
                end
            endcase
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (go && emit_now) begin
            r_out_found <= e_found;
            r_out_idx   <= e_idx;
            r_out_data  <= e_data;
            r_out_last  <= e_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.found       = r_out_found;
    assign o_res.match_index = r_out_idx;
    assign o_res.read_value  = r_out_data;
    assign o_res.last        = r_out_last;

    a_ram_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("RAM written and read in the same cycle");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_item.ready)
        else $error("ready stayed high after taking a command beat");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((ram_we || ram_re) && ctrl.addr_sel == abe_pkg::ASelPtr) |-> (r_ptr < n_len))
        else $error("element walk left the array in use");

    a_no_beat_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.in_rdy |-> !emit_now)
        else $error("result beat produced while waiting for a command");

endmodule

// File: rtl/abe_ram.sv
module abe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port: write, or read into the held output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/abe_useq.sv
module abe_useq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  abe_pkg::t_stat i_stat,
    output abe_pkg::t_ctrl o_ctrl
);

    abe_pkg::t_step r_step;
    abe_pkg::t_step n_step;
    abe_pkg::t_ctrl ctrl;
    abe_pkg::t_step step_inc;

    // Fetch the control word for the current step
    assign ctrl     = abe_pkg::ucode(r_step);
    assign o_ctrl   = ctrl;
    assign step_inc = r_step + abe_pkg::t_step'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= abe_pkg::StepIdle;
        end else begin
            r_step <= n_step;
        end
    end

    // Pick the next step: hold on a stall, else follow the jump condition
    always_comb begin
        n_step = r_step;
        if (!i_stat.stall) begin
            unique case (ctrl.cond)
                abe_pkg::CondNext:     n_step = step_inc;
                abe_pkg::CondAlways:   n_step = ctrl.target;
                abe_pkg::CondDispatch: n_step = i_stat.accept ?
                                                abe_pkg::dispatch(i_stat.cmd) : r_step;
                abe_pkg::CondShort:    n_step = i_stat.short_len ? ctrl.target : step_inc;
                abe_pkg::CondEmpty:    n_step = i_stat.empty ? ctrl.target : step_inc;
                abe_pkg::CondNotEnd:   n_step = !i_stat.at_end ? ctrl.target : step_inc;
                abe_pkg::CondStepEnd:  n_step = i_stat.step_end ? ctrl.target : step_inc;
                default:               n_step = abe_pkg::StepIdle;
            endcase
        end
    end

    a_step_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_step) < abe_pkg::StepCount)
        else $error("step counter left the program");

endmodule

// File: test/array_buffer_engine_core_test.sv
`timescale 1ns / 100ps

module array_buffer_engine_core_test;
    import abe_pkg::*;

    localparam int HalfPeriod       = 10;
    localparam int ResetCycles      = 7;
    localparam int StallLimit       = 5000;
    localparam int HoldCycles       = 400;
    localparam int SettleCycles     = 20;
    localparam int RandomPhaseItems = 45;
    localparam int RandomPhases     = 11;
    localparam int MaxReports       = 40;
    localparam int KeyPoolSize      = 8;

    // Command codes the block treats as no-ops
    localparam logic [CmdBits-1:0] CmdSpareLo = 3'd6;
    localparam logic [CmdBits-1:0] CmdSpareHi = 3'd7;

    typedef enum int {
        RxOpen,
        RxCoin,
        RxSparse,
        RxPattern
    } t_rx_mode;

    typedef enum int {
        TxSteady,
        TxBursty
    } t_tx_mode;

    typedef struct packed {
        logic [CmdBits-1:0] cmd;
        logic [PosBits-1:0] pos;
        logic [ValBits-1:0] val;
        logic               wait_idle;
    } t_item;

    typedef struct packed {
        logic               found;
        logic [IdxBits-1:0] idx;
        logic [RdBits-1:0]  data;
        logic               last;
    } t_beat;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [CfgBits-1:0] cfg_wr_data;

    abe_in_if  item_if ();
    abe_out_if res_if ();

    array_buffer_engine_core DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_item        (item_if),
        .o_res         (res_if)
    );

    // Mirror of the array and the length register
    t_word              array_mirror [Depth];
    logic [CfgBits-1:0] length_mirror;
    t_word              key_pool [KeyPoolSize];

    t_item pending_items [$];
    t_beat awaited_beats [$];

    int error_count    = 0;
    int reports_shown  = 0;
    int commands_taken = 0;
    int beats_checked  = 0;
    int search_hits    = 0;
    int search_misses  = 0;
    int settings_used  = 0;
    int stall_cycles   = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int rx_tick        = 0;
    int burst_left     = 0;
    int gap_left       = 0;

    t_rx_mode rx_mode = RxOpen;
    t_tx_mode tx_mode = TxSteady;
    bit       in_taken  = 1'b0;
    bit       out_taken = 1'b0;

    initial begin
        clk = 1'b0;
        forever #HalfPeriod clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (reports_shown < MaxReports) begin
            reports_shown++;
            $display("%0t ns mismatch: %s", $time, what);
        end
    endtask

    // Apply one command to the mirror and queue the beats it must produce
    task automatic predict_command(input t_item it);
        int    n;
        int    half;
        int    base;
        int    i;
        t_word keep;
        t_word key;
        t_word data;
        t_beat b;
        t_beat hits [$];
        n    = (int'(length_mirror) > Depth) ? Depth : int'(length_mirror);
        key  = t_word'(it.val);
        data = '0;
        case (it.cmd)
            CmdWrite: begin
                array_mirror[it.pos] = key;
            end
            CmdRead: begin
                data = array_mirror[it.pos];
            end
            CmdSwap: begin
                // odd length: the middle element stays put
                half = n / 2;
                base = half + (n % 2);
                for (i = 0; i < half; i++) begin
                    keep                  = array_mirror[i];
                    array_mirror[i]       = array_mirror[base + i];
                    array_mirror[base + i] = keep;
                end
            end
            CmdRotR: begin
                if (n >= 2) begin
                    keep = array_mirror[n - 1];
                    for (i = n - 1; i > 0; i--) begin
                        array_mirror[i] = array_mirror[i - 1];
                    end
                    array_mirror[0] = keep;
                end
            end
            CmdRotL: begin
                if (n >= 2) begin
                    keep = array_mirror[0];
                    for (i = 0; i + 1 < n; i++) begin
                        array_mirror[i] = array_mirror[i + 1];
                    end
                    array_mirror[n - 1] = keep;
                end
            end
            CmdSearch: begin
                for (i = 0; i < n; i++) begin
                    if (array_mirror[i] == key) begin
                        b.found = 1'b1;
                        b.idx   = i[IdxBits-1:0];
                        b.data  = '0;
                        b.last  = 1'b0;
                        hits.push_back(b);
                    end
                end
            end
            default: begin
            end
        endcase

        if (it.cmd == CmdSearch && hits.size() != 0) begin
            hits[hits.size() - 1].last = 1'b1;
            search_hits += hits.size();
            foreach (hits[k]) begin
                awaited_beats.push_back(hits[k]);
            end
        end else begin
            // single beat: ack, read data, or not-found
            b.found = (it.cmd == CmdSearch) ? 1'b0 : 1'b1;
            b.idx   = '0;
            b.data  = data;
            b.last  = 1'b1;
            if (it.cmd == CmdSearch) begin
                search_misses++;
            end
            awaited_beats.push_back(b);
        end
    endtask

    // Track accepted beats on both channels and check results
    always @(posedge clk) begin : observe
        t_item it;
        t_beat got;
        t_beat want;
        in_taken  = item_if.valid && item_if.ready;
        out_taken = res_if.valid && res_if.ready;
        if (!rst_n) begin
            length_mirror = LengthReset;
            stall_cycles  = 0;
        end else begin
            if (cfg_wr_en) begin
                length_mirror = cfg_wr_data;
            end
            if (in_taken) begin
                it.cmd       = item_if.command;
                it.pos       = item_if.position;
                it.val       = item_if.value;
                it.wait_idle = 1'b0;
                predict_command(it);
                commands_taken++;
            end
            if (out_taken) begin
                got.found = res_if.found;
                got.idx   = res_if.match_index;
                got.data  = res_if.read_value;
                got.last  = res_if.last;
                if (awaited_beats.size() == 0) begin
                    report_mismatch($sformatf("result beat with none expected: found=%0b idx=%0d data=%h last=%0b",
                                              got.found, got.idx, got.data, got.last));
                end else begin
                    want = awaited_beats.pop_front();
                    beats_checked++;
                    if (got.found !== want.found) begin
                        report_mismatch($sformatf("beat %0d found=%0b, expected %0b",
                                                  beats_checked, got.found, want.found));
                    end
                    if (got.idx !== want.idx) begin
                        report_mismatch($sformatf("beat %0d match_index=%0d, expected %0d",
                                                  beats_checked, got.idx, want.idx));
                    end
                    if (got.data !== want.data) begin
                        report_mismatch($sformatf("beat %0d read_value=%h, expected %h",
                                                  beats_checked, got.data, want.data));
                    end
                    if (got.last !== want.last) begin
                        report_mismatch($sformatf("beat %0d last=%0b, expected %0b",
                                                  beats_checked, got.last, want.last));
                    end
                end
            end
            // count cycles of outstanding work without any beat moving
            if (in_taken || out_taken ||
                (pending_items.size() == 0 && !item_if.valid && awaited_beats.size() == 0)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
    end

    // Offer items from the queue, in bursts in bursty mode; hold a beat until it is taken
    always @(negedge clk) begin : tx_drive
        t_item it;
        bit    offer;
        if (!(item_if.valid && !in_taken)) begin
            offer = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].wait_idle && awaited_beats.size() != 0)) begin
                it    = pending_items.pop_front();
                offer = 1'b1;
                if (tx_mode == TxBursty) begin
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = $urandom_range(0, 12);
                    end
                end
            end
            item_if.valid <= offer;
            if (offer) begin
                item_if.command  <= it.cmd;
                item_if.position <= it.pos;
                item_if.value    <= it.val;
            end
        end
    end

    // Drive result ready: long hold-off on request, else the phase pattern
    always @(negedge clk) begin : rx_drive
        logic rdy;
        if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HoldCycles;
        end
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else begin
            case (rx_mode)
                RxOpen:   rdy = 1'b1;
                RxCoin:   rdy = ($urandom_range(0, 1) == 1);
                RxSparse: rdy = ($urandom_range(0, 3) == 0);
                default:  rdy = ((rx_tick % 11) < 6);
            endcase
        end
        res_if.ready <= rdy;
    end

    initial begin : watchdog
        wait (stall_cycles >= StallLimit);
        $display("no beat moved for %0d cycles with work outstanding", StallLimit);
        $display("** array_buffer_engine_core: FAILED **");
        $finish;
    end

    function automatic logic [ValBits-1:0] pick_value();
        if ($urandom_range(0, 9) < 7) begin
            return ValBits'(key_pool[$urandom_range(0, KeyPoolSize - 1)]);
        end
        return ValBits'($urandom);
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            it.cmd = CmdWrite;
        end else if (roll < 50) begin
            it.cmd = CmdRead;
        end else if (roll < 60) begin
            it.cmd = CmdSwap;
        end else if (roll < 68) begin
            it.cmd = CmdRotR;
        end else if (roll < 76) begin
            it.cmd = CmdRotL;
        end else if (roll < 95) begin
            it.cmd = CmdSearch;
        end else begin
            it.cmd = ($urandom_range(0, 1) == 0) ? CmdSpareLo : CmdSpareHi;
        end
        it.pos = PosBits'($urandom);
        if (it.cmd == CmdWrite || it.cmd == CmdSearch) begin
            it.val = pick_value();
        end else begin
            it.val = ValBits'($urandom);
        end
        it.wait_idle = ($urandom_range(0, 29) == 0);
        return it;
    endfunction

    task automatic add_item(input logic [CmdBits-1:0] cmd, input int pos, input int val,
                            input bit wait_idle);
        t_item it;
        it.cmd       = cmd;
        it.pos       = PosBits'(pos);
        it.val       = ValBits'(val);
        it.wait_idle = wait_idle;
        pending_items.push_back(it);
    endtask

    task automatic write_length(input int len);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CfgBits'(len);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    // Wait until every item is taken and every result has come, then settle
    task automatic drain();
        while (pending_items.size() != 0 || item_if.valid || awaited_beats.size() != 0) begin
            @(posedge clk);
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    initial begin : sequencer
        int lengths [RandomPhases];
        int p;
        int k;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        item_if.valid    = 1'b0;
        item_if.command  = '0;
        item_if.position = '0;
        item_if.value    = '0;
        res_if.ready     = 1'b0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (k = 2; k < KeyPoolSize; k++) begin
            key_pool[k] = t_word'($urandom);
        end

        repeat (ResetCycles) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Fill every element so no read or search touches an unwritten one
        write_length(Depth);
        for (k = 0; k < Depth; k++) begin
            add_item(CmdWrite, k, pick_value(), 1'b0);
        end
        drain();

        // Full length: field extremes and every command
        add_item(CmdRead, 0, 0, 1'b1);
        add_item(CmdRead, Depth - 1, 16'hFFFF, 1'b0);
        add_item(CmdWrite, 0, 0, 1'b0);
        add_item(CmdWrite, Depth - 1, 16'hFFFF, 1'b0);
        add_item(CmdSearch, 0, 0, 1'b0);
        add_item(CmdSearch, Depth - 1, 16'hFFFF, 1'b0);
        add_item(CmdRotR, 0, 0, 1'b0);
        add_item(CmdRead, 0, 0, 1'b0);
        add_item(CmdRotL, 0, 0, 1'b0);
        add_item(CmdSwap, 0, 0, 1'b0);
        add_item(CmdSpareLo, Depth - 1, 16'hFFFF, 1'b0);
        add_item(CmdSpareHi, 0, 0, 1'b0);
        add_item(CmdSearch, 0, $urandom, 1'b0);
        drain();

        // Empty array; read beyond the length
        write_length(0);
        add_item(CmdSwap, 0, 0, 1'b0);
        add_item(CmdRotR, 0, 0, 1'b0);
        add_item(CmdRotL, 0, 0, 1'b0);
        add_item(CmdSearch, 0, 0, 1'b0);
        add_item(CmdRead, 40, 0, 1'b0);
        drain();

        // One element
        write_length(1);
        add_item(CmdSwap, 0, 0, 1'b0);
        add_item(CmdRotL, 0, 0, 1'b0);
        add_item(CmdSearch, 0, 0, 1'b0);
        drain();

        // Odd length swap around the middle element
        write_length(7);
        add_item(CmdWrite, 3, key_pool[2], 1'b0);
        add_item(CmdSwap, 0, 0, 1'b0);
        add_item(CmdRead, 3, 0, 1'b0);
        drain();

        // Length above the depth acts as full depth
        write_length(127);
        add_item(CmdRotR, 0, 0, 1'b0);
        add_item(CmdSearch, 0, 16'hFFFF, 1'b0);
        drain();

        // Random phases over a spread of lengths and handshake patterns
        lengths = '{64, 127, 2, 33, 0, 1, 64, 5, 0, 0, 64};
        lengths[8] = $urandom_range(0, 127);
        lengths[9] = $urandom_range(1, 16);
        for (p = 0; p < RandomPhases; p++) begin
            write_length(lengths[p]);
            rx_mode    = t_rx_mode'(p % 4);
            tx_mode    = (p % 3 == 0) ? TxSteady : TxBursty;
            burst_left = 0;
            for (k = 0; k < RandomPhaseItems; k++) begin
                pending_items.push_back(random_item());
            end
            // back up the output while the sender keeps offering
            if (lengths[p] == Depth) begin
                hold_requests++;
            end
            drain();
        end

        $display("covered %0d commands over %0d length settings, %0d result beats checked",
                 commands_taken, settings_used, beats_checked);
        $display("search matches %0d, not-found searches %0d, mismatches %0d",
                 search_hits, search_misses, error_count);
        if (error_count == 0) begin
            $display("** array_buffer_engine_core: PASSED **");
        end else begin
            $display("** array_buffer_engine_core: FAILED **");
        end
        $finish;
    end

endmodule
